// ----- src/nzda_pkg.sv -----
// Package for the NMEA ZDA time extractor: line record type, character codes,
// prefix and month-length lookups. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nzda_pkg;

  localparam int LINE_CAPACITY_DEF = 128;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [2:0] PREFIX_LEN = 3'd6;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_P     = 8'd80;

  // Time characters are taken as (code - 48) mod 256; missing ones count as code 0.
  localparam logic [7:0] DIGIT_BIAS   = 8'd208;
  localparam logic [6:0] MISSING_LOW  = 7'd80;
  localparam logic [6:0] MISSING_PAIR = 7'd112;

  localparam logic [3:0] FLD_TIME  = 4'd1;
  localparam logic [3:0] FLD_DAY   = 4'd2;
  localparam logic [3:0] FLD_YEAR  = 4'd4;
  localparam logic [3:0] FLD_LAST  = 4'd15;

  localparam logic [13:0] ACC_SAT  = 14'd16383;
  localparam logic [13:0] YEAR_MIN = 14'd2000;
  localparam logic [13:0] YEAR_MAX = 14'd2099;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [7:0] HOURS_DAY = 8'd24;
  localparam logic [4:0] DAYS_LEAP_FEB = 5'd29;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOT_ZDA = 2'd1;
  localparam logic [1:0] ST_BAD_DATE = 2'd2;

  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_GP     = 1'b1;
  localparam logic [4:0] OFFSET_RST = 5'd8;

  // One finished line, handed from the parser to the date/time stage.
  typedef struct packed {
    logic        not_zda;
    logic [13:0] day;
    logic [13:0] month;
    logic [13:0] year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } rec_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'd36;  // $
      3'd1:    ch = 8'd71;  // G
      3'd2:    ch = 8'd78;  // N
      3'd3:    ch = 8'd90;  // Z
      3'd4:    ch = 8'd68;  // D
      3'd5:    ch = 8'd65;  // A
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                     len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- src/nzda_front.sv -----
// Byte parser: tracks prefix, comma tokens, time digits and date numbers per byte.
// Emits one nzda_pkg::rec_t per line feed accepted within the line capacity. Depends on nzda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nzda_front #(
  parameter int LINE_CAPACITY = nzda_pkg::LINE_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          rx_byte,
  input  logic                accept_gp,
  output logic                rec_wr,
  output nzda_pkg::rec_t      rec
);
  import nzda_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  logic [2:0]       pos_r, pos_p;
  logic             mism_r, mism_p;
  logic [3:0]       field_r, field_p;
  logic             tok_r, tok_p;
  logic [2:0]       tcnt_r, tcnt_p;
  logic [6:0]       hour_r, hour_p, min_r, min_p, sec_r, sec_p;
  logic [13:0]      day_r, day_p, mon_r, mon_p, yr_r, yr_p;
  logic [2:0]       ended_r, ended_p;
  logic             started_r, started_p;
  logic [LEN_W-1:0] len_r;

  logic [7:0]  tv;
  logic [6:0]  ten_v;
  logic [1:0]  k;
  logic [13:0] acc, acc_n;
  logic [17:0] nsum;
  logic        drop, is_lf;

  assign drop  = (len_r >= LEN_MAX);
  assign is_lf = (rx_byte == CH_LF);
  assign tv    = rx_byte + DIGIT_BIAS;
  assign ten_v = tv[6:0] * 7'd10;
  assign k     = 2'(field_r - FLD_DAY);
  assign nsum  = {4'b0, acc} * 18'd10 + {10'b0, rx_byte - CH_ZERO};

  always_comb begin
    case (k)
      2'd0:    acc = day_r;
      2'd1:    acc = mon_r;
      default: acc = yr_r;
    endcase
  end

  always_comb begin
    pos_p     = pos_r;
    mism_p    = mism_r;
    field_p   = field_r;
    tok_p     = tok_r;
    tcnt_p    = tcnt_r;
    hour_p    = hour_r;
    min_p     = min_r;
    sec_p     = sec_r;
    day_p     = day_r;
    mon_p     = mon_r;
    yr_p      = yr_r;
    ended_p   = ended_r;
    started_p = started_r;
    acc_n     = acc;

    if (pos_r < PREFIX_LEN) begin
      if (!(rx_byte == prefix_char(pos_r) ||
            (pos_r == 3'd2 && accept_gp && rx_byte == CH_P))) begin
        mism_p = 1'b1;
      end
      pos_p = pos_r + 3'd1;
    end

    if (rx_byte == CH_COMMA) begin
      // close a token; empty fields leave the count alone
      if (tok_r) begin
        tok_p = 1'b0;
        if (field_r != FLD_LAST) begin
          field_p = field_r + 4'd1;
        end
      end
    end else begin
      if (!tok_r) begin
        tok_p     = 1'b1;
        started_p = 1'b0;
      end
      if (field_r == FLD_TIME) begin
        if (tcnt_r < 3'd6) begin
          case (tcnt_r[2:1])
            2'd0:    hour_p = tcnt_r[0] ? hour_r + tv[6:0] : ten_v;
            2'd1:    min_p  = tcnt_r[0] ? min_r + tv[6:0] : ten_v;
            default: sec_p  = tcnt_r[0] ? sec_r + tv[6:0] : ten_v;
          endcase
          tcnt_p = tcnt_r + 3'd1;
        end
      end else if (field_r >= FLD_DAY && field_r <= FLD_YEAR) begin
        if (!ended_r[k]) begin
          if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
            acc_n     = (nsum > {4'b0, ACC_SAT}) ? ACC_SAT : nsum[13:0];
            started_p = 1'b1;
          end else if (!started_p && (rx_byte == CH_SPACE ||
                                       rx_byte inside {[CH_TAB:CH_CR]})) begin
            // skip leading white space
          end else if (!started_p && rx_byte == CH_PLUS) begin
            started_p = 1'b1;
          end else begin
            if (!started_p && rx_byte == CH_MINUS) begin
              acc_n = '0;
            end
            ended_p[k] = 1'b1;
          end
          case (k)
            2'd0:    day_p = acc_n;
            2'd1:    mon_p = acc_n;
            default: yr_p  = acc_n;
          endcase
        end
      end
    end
  end

  // Line record built from the state after the line feed itself is parsed.
  always_comb begin
    rec.not_zda = mism_p || (pos_p < PREFIX_LEN);
    rec.day     = day_p;
    rec.month   = mon_p;
    rec.year    = yr_p;
    rec.hour    = (tcnt_p >= 3'd2) ? hour_p :
                  (tcnt_p == 3'd1) ? hour_p + MISSING_LOW : MISSING_PAIR;
    rec.minute  = (tcnt_p >= 3'd4) ? min_p :
                  (tcnt_p == 3'd3) ? min_p + MISSING_LOW : MISSING_PAIR;
    rec.second  = (tcnt_p == 3'd6) ? sec_p :
                  (tcnt_p == 3'd5) ? sec_p + MISSING_LOW : MISSING_PAIR;
  end

  assign rec_wr = byte_valid && !drop && is_lf;

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_valid && (drop || is_lf))) begin
      pos_r     <= '0;
      mism_r    <= 1'b0;
      field_r   <= '0;
      tok_r     <= 1'b0;
      tcnt_r    <= '0;
      hour_r    <= '0;
      min_r     <= '0;
      sec_r     <= '0;
      day_r     <= '0;
      mon_r     <= '0;
      yr_r      <= '0;
      ended_r   <= '0;
      started_r <= 1'b0;
      len_r     <= '0;
    end else if (byte_valid) begin
      pos_r     <= pos_p;
      mism_r    <= mism_p;
      field_r   <= field_p;
      tok_r     <= tok_p;
      tcnt_r    <= tcnt_p;
      hour_r    <= hour_p;
      min_r     <= min_p;
      sec_r     <= sec_p;
      day_r     <= day_p;
      mon_r     <= mon_p;
      yr_r      <= yr_p;
      ended_r   <= ended_p;
      started_r <= started_p;
      len_r     <= len_r + LEN_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- src/nzda_queue.sv -----
// Short record queue between the parser and the date/time stage.
// Depends on nzda_pkg (rec_t, QUEUE_DEPTH).
`timescale 1ns / 1ps
`default_nettype none
module nzda_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  nzda_pkg::rec_t din,
  input  logic           rd,
  output nzda_pkg::rec_t dout,
  output logic           valid,
  output logic           full
);
  import nzda_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  rec_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign valid = (cnt_r != '0);
  assign full  = (cnt_r == CNT_FULL);
  assign dout  = slot_r[rptr_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/nzda_back.sv -----
// Date/time stage: range check, local-offset hour add, one-day date advance,
// and the result register. Depends on nzda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nzda_back (
  input  logic           clk,
  input  logic           rst_n,
  input  nzda_pkg::rec_t rec,
  input  logic           rec_valid,
  input  logic [4:0]     utc_offset,
  output logic           rec_take,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     status,
  output logic [6:0]     local_hour,
  output logic [6:0]     minute_value,
  output logic [6:0]     second_value,
  output logic [4:0]     day_of_month,
  output logic [3:0]     month_number,
  output logic [6:0]     year_offset
);
  import nzda_pkg::*;

  logic       vld_r;
  logic [1:0] st_nxt;
  logic [6:0] hr_nxt, mn_nxt, sc_nxt, yr_nxt;
  logic [4:0] dy_nxt, lim;
  logic [3:0] mo_nxt;
  logic [7:0] hsum;
  logic [5:0] d6;
  logic [3:0] m4;
  logic [6:0] y7;
  logic       in_range;

  assign in_range = rec.day >= 14'd1 && rec.day <= 14'd31 &&
                    rec.month >= 14'd1 && rec.month <= 14'd12 &&
                    rec.year >= YEAR_MIN && rec.year <= YEAR_MAX;

  always_comb begin
    hsum = {1'b0, rec.hour} + {3'b0, utc_offset};
    d6   = {1'b0, rec.day[4:0]};
    m4   = rec.month[3:0];
    y7   = 7'(rec.year - YEAR_MIN);
    lim  = month_len(m4);
    if (m4 == MONTH_FEB && y7[1:0] == 2'b00) begin
      lim = DAYS_LEAP_FEB;
    end
    if (hsum >= HOURS_DAY) begin
      hsum = hsum - HOURS_DAY;
      d6   = d6 + 6'd1;
      if (d6 > {1'b0, lim}) begin
        d6 = 6'd1;
        m4 = m4 + 4'd1;
        if (m4 > MONTH_DEC) begin
          m4 = 4'd1;
          y7 = y7 + 7'd1;
        end
      end
    end

    st_nxt = ST_OK;
    hr_nxt = hsum[6:0];
    mn_nxt = rec.minute;
    sc_nxt = rec.second;
    dy_nxt = d6[4:0];
    mo_nxt = m4;
    yr_nxt = y7;
    if (rec.not_zda || !in_range) begin
      st_nxt = rec.not_zda ? ST_NOT_ZDA : ST_BAD_DATE;
      hr_nxt = '0;
      mn_nxt = '0;
      sc_nxt = '0;
      dy_nxt = '0;
      mo_nxt = '0;
      yr_nxt = '0;
    end
  end

  // load whenever the result register is free or being drained this cycle
  assign rec_take = rec_valid && (!vld_r || pop);
  assign empty    = !vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rec_take) begin
      vld_r <= 1'b1;
    end else if (pop) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      status       <= st_nxt;
      local_hour   <= hr_nxt;
      minute_value <= mn_nxt;
      second_value <= sc_nxt;
      day_of_month <= dy_nxt;
      month_number <= mo_nxt;
      year_offset  <= yr_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/nmea_zda_time_extractor_unit.sv -----
// A line feed's record goes into the queue, then into the result register (empty low) once it is free or popped.
// Throughput: one byte per cycle while full is low; the parser registers its per-byte state on each accepted byte.
// A result waits in the output register while up to two more finished lines queue behind it.
// Reset (rst_n low, synchronous): parse state, queue and result cleared; offset 8, GP off.
// Top level: APB registers plus nzda_front, nzda_queue, nzda_back; depends on nzda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nmea_zda_time_extractor_unit #(
  parameter int LINE_CAPACITY = nzda_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [6:0]  out_local_hour,
  output logic [6:0]  out_minute_value,
  output logic [6:0]  out_second_value,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_number,
  output logic [6:0]  out_year_offset,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nzda_pkg::*;

  logic [4:0] offset_r;
  logic       gp_r;
  logic       cfg_wr;
  logic       byte_valid;
  logic       q_wr, q_valid, q_full, q_take;
  rec_t       q_din, q_dout;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      gp_r     <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_OFFSET) begin
        offset_r <= pwdata[4:0];
      end else begin
        gp_r <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_GP) ? {31'b0, gp_r} : {27'b0, offset_r};

  assign full       = q_full;
  assign byte_valid = push && !full;

  nzda_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_valid),
    .rx_byte   (in_rx_byte),
    .accept_gp (gp_r),
    .rec_wr    (q_wr),
    .rec       (q_din)
  );

  nzda_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (q_wr),
    .din  (q_din),
    .rd   (q_take),
    .dout (q_dout),
    .valid(q_valid),
    .full (q_full)
  );

  nzda_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec         (q_dout),
    .rec_valid   (q_valid),
    .utc_offset  (offset_r),
    .rec_take    (q_take),
    .pop         (pop),
    .empty       (empty),
    .status      (out_status),
    .local_hour  (out_local_hour),
    .minute_value(out_minute_value),
    .second_value(out_second_value),
    .day_of_month(out_day_of_month),
    .month_number(out_month_number),
    .year_offset (out_year_offset)
  );

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> !q_full) else $error("parser wrote a full record queue");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |->
      (out_local_hour == 7'd0 && out_minute_value == 7'd0 && out_second_value == 7'd0 &&
       out_day_of_month == 5'd0 && out_month_number == 4'd0 && out_year_offset == 7'd0))
    else $error("error result carries nonzero fields");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_OK) |->
      (out_day_of_month >= 5'd1 && out_month_number >= 4'd1 &&
       out_month_number <= MONTH_DEC && out_year_offset <= 7'd100))
    else $error("valid result holds a date out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty) else $error("result not cleared by reset");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking bench for nmea_zda_time_extractor_unit: byte driver, result monitor and
// a per-byte line parser that predicts each status, local time and date.
// Depends on nzda_pkg and the unit under test; needs nothing else.
`timescale 1ns / 1ps
module tb;
  import nzda_pkg::*;

  localparam int LINE_CAP    = LINE_CAPACITY_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 600;
  localparam int PHASE_BYTES = 195;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } zda_fix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_status;
  logic [6:0]  out_local_hour;
  logic [6:0]  out_minute_value;
  logic [6:0]  out_second_value;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month_number;
  logic [6:0]  out_year_offset;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  nmea_zda_time_extractor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_rx_byte(in_rx_byte),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_local_hour(out_local_hour),
    .out_minute_value(out_minute_value), .out_second_value(out_second_value),
    .out_day_of_month(out_day_of_month), .out_month_number(out_month_number),
    .out_year_offset(out_year_offset),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  logic [7:0] byte_backlog[$];
  zda_fix_t   expected_fixes[$];
  int failures = 0;
  int quiet_cycles = 0;
  int tx_gap_pct = 0;
  int rx_gap_pct = 0;
  int tx_gap_left = 0;
  int rx_hold_left = 0;
  bit want_long_hold = 0;
  bit long_hold_done = 0;

  // Register copies seen by the line parser
  int utc_shift = 8;
  bit gp_ok = 0;

  // Line parser state
  logic [7:0] zda_hdr[6] = '{8'h24, 8'h47, 8'h4E, 8'h5A, 8'h44, 8'h41}; // $GNZDA
  int month_len_tbl[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int pfx_pos, tok_idx, tdig_cnt, line_len;
  bit pfx_bad, tok_open, num_begun;
  int tpair[3];
  int date_acc[3];
  bit [2:0] num_done;

  function automatic void clear_parse();
    pfx_pos = 0; pfx_bad = 0; tok_idx = 0; tok_open = 0; tdig_cnt = 0;
    tpair = '{0, 0, 0};
    date_acc = '{0, 0, 0};
    num_done = 3'b000; num_begun = 0; line_len = 0;
  endfunction

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Time characters are not checked: each is (code - '0') mod 256
  function automatic void time_digit(int c);
    int v;
    if (tdig_cnt >= 6) return;
    v = (c - int'(CH_ZERO)) & 255;
    if (tdig_cnt % 2 == 0) tpair[tdig_cnt / 2] = (v * 10) & 127;
    else tpair[tdig_cnt / 2] = (tpair[tdig_cnt / 2] + v) & 127;
    tdig_cnt++;
  endfunction

  function automatic void number_digit(int k, logic [7:0] c);
    int n;
    if (num_done[k]) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      n = date_acc[k] * 10 + (int'(c) - int'(CH_ZERO));
      date_acc[k] = (n > 16383) ? 16383 : n;
      num_begun = 1;
    end else if (!num_begun && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
      // skip leading blanks
    end else if (!num_begun && c == CH_PLUS) begin
      num_begun = 1;
    end else begin
      if (!num_begun && c == CH_MINUS) date_acc[k] = 0;
      num_done[k] = 1'b1;
    end
  endfunction

  function automatic zda_fix_t resolve_fix();
    zda_fix_t f;
    int d, m, y, h, lim;
    f = '0;
    if (pfx_bad || pfx_pos < 6) begin
      f.status = ST_NOT_ZDA;
      return f;
    end
    d = date_acc[0]; m = date_acc[1]; y = date_acc[2];
    if (d < 1 || d > 31 || m < 1 || m > 12 || y < 2000 || y > 2099) begin
      f.status = ST_BAD_DATE;
      return f;
    end
    y -= 2000;
    while (tdig_cnt < 6) time_digit(0);
    h = tpair[0] + utc_shift;
    if (h >= 24) begin
      h -= 24;
      d++;
      lim = month_len_tbl[m - 1];
      if (m == 2 && leap_year(y)) lim = 29;
      if (d > lim) begin
        d = 1;
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
    end
    f.status = ST_OK;
    f.hour = 7'(h);
    f.minute = 7'(tpair[1]);
    f.second = 7'(tpair[2]);
    f.day = 5'(d);
    f.month = 4'(m);
    f.year = 7'(y);
    return f;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b, output bit fix_ready, output zda_fix_t fix);
    fix_ready = 0;
    fix = '0;
    // A full line drops this byte, line feed or not, and starts over
    if (line_len >= LINE_CAP - 1) begin
      clear_parse();
      return;
    end
    line_len++;
    if (pfx_pos < 6) begin
      if (!(b == zda_hdr[pfx_pos] || (pfx_pos == 2 && gp_ok && b == CH_P))) pfx_bad = 1;
      pfx_pos++;
    end
    if (b == CH_COMMA) begin
      if (tok_open) begin
        tok_open = 0;
        if (tok_idx < 15) tok_idx++;
      end
    end else begin
      if (!tok_open) begin
        tok_open = 1;
        num_begun = 0;
      end
      if (tok_idx == 1) time_digit(b);
      else if (tok_idx >= 2 && tok_idx <= 4) number_digit(tok_idx - 2, b);
    end
    if (b == CH_LF) begin
      fix_ready = 1;
      fix = resolve_fix();
      clear_parse();
    end
  endtask

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      failures++;
    end
  endfunction

  // Byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (tx_gap_left > 0) begin
        push <= 1'b0;
        tx_gap_left <= tx_gap_left - 1;
      end else if (byte_backlog.size() == 0) begin
        push <= 1'b0;
      end else if ($urandom_range(0, 99) < tx_gap_pct) begin
        push <= 1'b0;
        tx_gap_left <= $urandom_range(0, 6);
      end else begin
        push <= 1'b1;
        in_rx_byte <= byte_backlog.pop_front();
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      pop <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (want_long_hold && !long_hold_done) begin
      pop <= 1'b0;
      long_hold_done <= 1'b1;
      rx_hold_left <= LONG_HOLD;
    end else if ($urandom_range(0, 99) < rx_gap_pct) begin
      pop <= 1'b0;
      rx_hold_left <= $urandom_range(0, 6);
    end else begin
      pop <= 1'b1;
    end
  end

  // Monitor: predict on each accepted byte, check each accepted result beat
  always @(posedge clk) begin : monitor_blk
    bit fix_ready;
    zda_fix_t fix, want;
    if (rst_n) begin
      if (push && !full) begin
        parse_rx_byte(in_rx_byte, fix_ready, fix);
        if (fix_ready) expected_fixes.push_back(fix);
      end
      if (pop && !empty) begin
        if (expected_fixes.size() == 0) begin
          $error("result beat with no line pending: status %0d", out_status);
          failures++;
        end else begin
          want = expected_fixes.pop_front();
          check_field("status", want.status, out_status);
          check_field("local_hour", want.hour, out_local_hour);
          check_field("minute_value", want.minute, out_minute_value);
          check_field("second_value", want.second, out_second_value);
          check_field("day_of_month", want.day, out_day_of_month);
          check_field("month_number", want.month, out_month_number);
          check_field("year_offset", want.year, out_year_offset);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (byte_backlog.size() != 0 || push || expected_fixes.size() != 0) @(posedge clk);
    // let a trailing non-line-feed byte settle in the parser
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    if (idx == REG_OFFSET) utc_shift = val & 31;
    else gp_ok = val[0];
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_OFFSET) check_field("utc_offset_hours readback", val & 31, prdata[4:0]);
    else check_field("accept_gp_talker readback", val & 1, prdata[0]);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic string num_text(int v, int width);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < width) s = {"0", s};
    return s;
  endfunction

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) byte_backlog.push_back(s[i]);
  endtask

  task automatic put_comma(bit mangle);
    put_text(",");
    if (mangle && $urandom_range(0, 3) == 0) put_text(",");
  endtask

  task automatic put_number(int v, bit mangle);
    if (mangle) begin
      if ($urandom_range(0, 9) == 0) return;
      case ($urandom_range(0, 9))
        0: put_text(" ");
        1: put_text("\t");
        2: put_text("+");
        3: put_text(" +");
        4: put_text("-");
        5: put_text("0");
        default: ;
      endcase
    end
    put_text(num_text(v, $urandom_range(0, 3)));
    if (mangle && $urandom_range(0, 5) == 0) put_text("x");
  endtask

  // ZDA line with random content, mangled when mangle is set; month ends are favored to force date rollover
  task automatic add_fix_line(bit mangle);
    int mo, dy, yr, hr, lim;
    mo = $urandom_range(1, 12);
    yr = 2000 + $urandom_range(0, 99);
    lim = month_len_tbl[mo - 1];
    if (mo == 2 && leap_year(yr - 2000)) lim = 29;
    dy = ($urandom_range(0, 2) == 0) ? lim : $urandom_range(1, 31);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: yr = 1999;
        1: yr = 2100;
        2: yr = 0;
        default: yr = 20000;
      endcase
    end
    hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    if ($urandom_range(0, 2) == 0) put_text("$GPZDA");
    else put_text("$GNZDA");
    put_comma(mangle);
    if (mangle && $urandom_range(0, 5) == 0) begin
      put_text(num_text($urandom_range(0, 9999), 0));
    end else begin
      put_text({num_text(hr, 2), num_text($urandom_range(0, 59), 2),
                num_text($urandom_range(0, 60), 2)});
    end
    if ($urandom_range(0, 1) == 1) put_text({".", num_text($urandom_range(0, 99), 2)});
    put_comma(mangle);
    put_number(dy, mangle);
    put_comma(mangle);
    put_number(mo, mangle);
    put_comma(mangle);
    put_number(yr, mangle);
    if ($urandom_range(0, 1) == 1) put_text(",00,00*5A\r\n");
    else put_text("\n");
  endtask

  task automatic add_random_line();
    string s;
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      add_fix_line(r < 25);
    end else if (r < 70) begin
      s = "$GNZDA";
      s[$urandom_range(0, 5)] = 8'($urandom_range(33, 126));
      put_text({s, ",120000,01,01,2020\n"});
    end else if (r < 80) begin
      s = "$GNZDA,123456,15,07,2033";
      put_text({s.substr(0, $urandom_range(0, s.len() - 1)), "\n"});
    end else if (r < 92) begin
      n = $urandom_range(1, 40);
      repeat (n) byte_backlog.push_back(8'($urandom_range(0, 255)));
      put_text("\n");
    end else if (r < 96) begin
      put_text("$GNZDA,120000,01,01,2020,");
      n = $urandom_range(100, 200);
      repeat (n) byte_backlog.push_back(8'($urandom_range(11, 255)));
      put_text("\n");
    end else begin
      put_text("\r\n");
    end
  endtask

  task automatic put_padded_line(int total);
    string s;
    s = "$GNZDA,010203,15,06,2050,";
    put_text(s);
    repeat (total - s.len() - 1) put_text("x");
    put_text("\n");
  endtask

  task automatic run_phase(int offset, bit gp, int tx_pct, int rx_pct, bit hold);
    wait_idle();
    write_reg(REG_OFFSET, offset);
    write_reg(REG_GP, gp);
    tx_gap_pct = tx_pct;
    rx_gap_pct = rx_pct;
    want_long_hold = hold;
    while (byte_backlog.size() < PHASE_BYTES) add_random_line();
    wait_idle();
  endtask

  initial begin
    clear_parse();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines at reset register values
    tx_gap_pct = 10;
    rx_gap_pct = 10;
    put_text("$GNZDA,235959.00,31,12,2099,00,00*7F\r\n");
    put_text("$GPZDA,120000,01,01,2000\n");
    put_text("$GNZDA,,,201500,,28,,02,2024\n");
    put_text("$GNZDA,180000,29,02,2000\n");
    put_text("$GNZDA,170000,28,02,2023\n");
    put_text("$GNZDA,2A");
    byte_backlog.push_back(8'h00);
    byte_backlog.push_back(8'hFF);
    put_text(":9,  +07,\t+3,2024\n");
    put_text("$GNZDA,000000,-5,3,2020\n");
    put_text("$GNZDA,000000,99999999,1,2020\n");
    put_text("$GNZDA,000000,0,13,2100\n");
    put_text("$GNZDA,1\n");
    put_text("$GNZD\n");
    put_text("\n");
    put_padded_line(LINE_CAP - 1);
    put_padded_line(LINE_CAP);
    put_text("\n");
    // Talker byte checked against the register value at its own arrival
    put_text("$G");
    wait_idle();
    write_reg(REG_GP, 1);
    write_reg(REG_OFFSET, 0);
    put_text("PZDA,000000,31,01,2000\n");
    wait_idle();
    write_reg(REG_OFFSET, 23);
    put_text("$GNZDA,010000,31,12,2099\n");
    put_text("$GPZDA,235959,28,02,2100\n");

    run_phase(23, 1, 10, 0, 0);
    run_phase(0, 0, 30, 30, 0);
    run_phase(23, 0, 0, 20, 1);
    run_phase($urandom_range(0, 23), 1, 20, 0, 0);
    run_phase($urandom_range(0, 23), 0, 5, 5, 0);
    run_phase($urandom_range(0, 23), 1'($urandom_range(0, 1)), 0, 0, 0);

    wait_idle();
    repeat (6) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/nzda_pkg.sv
src/nzda_front.sv
src/nzda_queue.sv
src/nzda_back.sv
src/nmea_zda_time_extractor_unit.sv
tb/sv/tb.sv
